@@ hdl/dmxrdm_pkg.sv @@
package dmxrdm_pkg;

  // Counting and header capture
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned HEAD_DEPTH  = 8;
  localparam int unsigned HEAD_IDX_W  = 3;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 10'd519;

  // Event codes
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_BREAK   = 2'd1;
  localparam logic [1:0] ACT_ERROR   = 2'd2;
  localparam logic [1:0] ACT_TX_DONE = 2'd3;

  // Packet kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_DMX     = 3'd1;
  localparam logic [2:0] KIND_RDM     = 3'd2;
  localparam logic [2:0] KIND_DISC    = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // Port modes
  localparam logic [2:0] MODE_OFF         = 3'd0;
  localparam logic [2:0] MODE_DMX_OUT     = 3'd1;
  localparam logic [2:0] MODE_DMX_OUT_BLK = 3'd2;
  localparam logic [2:0] MODE_DMX_IN      = 3'd3;
  localparam logic [2:0] MODE_RDM_OUT     = 3'd4;
  localparam logic [2:0] MODE_RDM_IN      = 3'd5;
  localparam logic [2:0] MODE_DMX_RDM_IN  = 3'd6;
  localparam logic [2:0] MODE_UNUSED      = 3'd7;

  // Start codes and discovery preamble bytes
  localparam logic [7:0] SC_DMX       = 8'h00;
  localparam logic [7:0] SC_RDM       = 8'hCC;
  localparam logic [7:0] DISC_PRE     = 8'hFE;
  localparam logic [7:0] DISC_SEP     = 8'hAA;
  localparam logic [3:0] DISC_PRE_MIN = 4'd5;

  // Byte positions that trigger classification
  localparam logic [CNT_W-1:0] POS_START_CODE = 10'd2;
  localparam logic [CNT_W-1:0] POS_DISC_CHECK = 10'd7;
  localparam int unsigned      POS_RDM_LEN    = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_EN    = 2'd3;

  typedef struct packed {
    logic [2:0]       port_mode;
    logic [CNT_W-1:0] dmx_start_address;
    logic [CNT_W-1:0] dmx_channel_count;
    logic             packet_delay_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       transmitting;
  } in_t;

  typedef struct packed {
    logic             packet_done;
    logic [2:0]       packet_kind;
    logic             store_write;
    logic [CNT_W-1:0] store_index;
    logic             receive_armed;
    logic             timer_restart;
    logic             send_permit;
    logic             send_delay_start;
    logic             send_timeout_stop;
  } out_t;

endpackage

@@ hdl/dmxrdm_cfg_regs.sv @@
module dmxrdm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dmxrdm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [dmxrdm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dmxrdm_pkg::cfg_t                   cfg
);

  dmxrdm_pkg::cfg_t cfg_r;

  // Register file, written one field at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.port_mode           <= dmxrdm_pkg::MODE_OFF;
      cfg_r.dmx_start_address   <= 10'd1;
      cfg_r.dmx_channel_count   <= 10'd16;
      cfg_r.packet_delay_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dmxrdm_pkg::REG_PORT_MODE:  cfg_r.port_mode           <= cfg_wdata[2:0];
        dmxrdm_pkg::REG_START_ADDR: cfg_r.dmx_start_address   <= cfg_wdata[9:0];
        dmxrdm_pkg::REG_CHAN_COUNT: cfg_r.dmx_channel_count   <= cfg_wdata[9:0];
        dmxrdm_pkg::REG_DELAY_EN:   cfg_r.packet_delay_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/dmxrdm_core.sv @@
module dmxrdm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  dmxrdm_pkg::cfg_t  cfg,
  input  logic              step,
  input  dmxrdm_pkg::in_t   item,
  output dmxrdm_pkg::out_t  res
);

  localparam int unsigned CW = dmxrdm_pkg::CNT_W;

  // Framing state
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           brk_r, brk_nxt;
  logic [2:0]     kind_r, kind_nxt;
  logic           recv_r, recv_nxt;
  logic [dmxrdm_pkg::HEAD_DEPTH-1:0][7:0] head_r, head_nxt;

  logic [dmxrdm_pkg::HEAD_DEPTH-1:0][7:0] head_eff;
  logic [CW:0]    cnt_inc;
  logic [CW-1:0]  cnt_sat;
  logic [CW:0]    dmx_end;
  logic [CW:0]    rdm_end;
  logic [3:0]     fe_cnt;
  logic           disc_hit;
  logic           done;
  logic           do_tx;

  // Header bytes as they look once the current byte lands
  always_comb begin
    head_eff = head_r;
    if (cnt_r < CW'(dmxrdm_pkg::HEAD_DEPTH)) begin
      head_eff[cnt_r[dmxrdm_pkg::HEAD_IDX_W-1:0]] = item.data_byte;
    end
  end

  // Discovery response: an AA after at least five FE bytes
  always_comb begin
    fe_cnt   = '0;
    disc_hit = 1'b0;
    for (int i = 0; i < dmxrdm_pkg::HEAD_DEPTH; i++) begin
      if (fe_cnt >= dmxrdm_pkg::DISC_PRE_MIN && head_eff[i] == dmxrdm_pkg::DISC_SEP) begin
        disc_hit = 1'b1;
      end
      if (head_eff[i] == dmxrdm_pkg::DISC_PRE && fe_cnt < dmxrdm_pkg::DISC_PRE_MIN) begin
        fe_cnt = fe_cnt + 4'd1;
      end
    end
  end

  // Saturating count and packet end points
  assign cnt_inc = {1'b0, cnt_r} + (CW+1)'(1);
  assign cnt_sat = (cnt_inc > {1'b0, dmxrdm_pkg::COUNT_LIMIT}) ?
                   dmxrdm_pkg::COUNT_LIMIT : cnt_inc[CW-1:0];
  assign dmx_end = {1'b0, cfg.dmx_start_address} + {1'b0, cfg.dmx_channel_count};
  assign rdm_end = (CW+1)'(head_eff[dmxrdm_pkg::POS_RDM_LEN]) + (CW+1)'(2);

  // Per-event next state and result
  always_comb begin
    cnt_nxt  = cnt_r;
    brk_nxt  = brk_r;
    kind_nxt = kind_r;
    recv_nxt = recv_r;
    head_nxt = head_r;
    done     = 1'b0;
    do_tx    = 1'b0;
    res      = '0;

    unique case (item.action)
      dmxrdm_pkg::ACT_BYTE: begin
        if (recv_r) begin
          res.store_write = 1'b1;
          res.store_index = cnt_r;
          head_nxt        = head_eff;
          if (cnt_r == dmxrdm_pkg::POS_START_CODE) begin
            if (brk_r) begin
              if (head_eff[0] == dmxrdm_pkg::SC_DMX) begin
                kind_nxt = dmxrdm_pkg::KIND_DMX;
              end else if (head_eff[0] == dmxrdm_pkg::SC_RDM) begin
                kind_nxt = dmxrdm_pkg::KIND_RDM;
              end else begin
                kind_nxt = dmxrdm_pkg::KIND_UNKNOWN;
              end
            end
          end else if (cnt_r == dmxrdm_pkg::POS_DISC_CHECK && !brk_r &&
                       cfg.port_mode == dmxrdm_pkg::MODE_RDM_OUT) begin
            kind_nxt = disc_hit ? dmxrdm_pkg::KIND_DISC : dmxrdm_pkg::KIND_UNKNOWN;
          end
          cnt_nxt           = cnt_sat;
          recv_nxt          = (cfg.port_mode != dmxrdm_pkg::MODE_OFF);
          res.timer_restart = 1'b1;
          if (kind_nxt == dmxrdm_pkg::KIND_RDM) begin
            done = ({1'b0, cnt_sat} >= rdm_end);
          end else if (kind_nxt == dmxrdm_pkg::KIND_DMX) begin
            done = ({1'b0, cnt_sat} >= dmx_end);
          end
          if (done) begin
            cnt_nxt         = '0;
            recv_nxt        = 1'b0;
            res.packet_done = 1'b1;
          end
        end
      end
      dmxrdm_pkg::ACT_BREAK: begin
        head_nxt = '0;
        kind_nxt = dmxrdm_pkg::KIND_NONE;
        cnt_nxt  = '0;
        recv_nxt = 1'b1;
        brk_nxt  = 1'b1;
      end
      dmxrdm_pkg::ACT_ERROR: begin
        if (!item.transmitting) begin
          kind_nxt          = dmxrdm_pkg::KIND_ERROR;
          cnt_nxt           = cnt_sat;
          recv_nxt          = (cfg.port_mode != dmxrdm_pkg::MODE_OFF);
          res.timer_restart = 1'b1;
        end else begin
          recv_nxt = 1'b0;
          do_tx    = 1'b1;
        end
      end
      dmxrdm_pkg::ACT_TX_DONE: begin
        do_tx = 1'b1;
      end
    endcase

    // Transmit completion handling per port mode
    if (do_tx) begin
      unique case (cfg.port_mode)
        dmxrdm_pkg::MODE_DMX_OUT: begin
          res.send_timeout_stop = 1'b1;
          if (cfg.packet_delay_enable) begin
            cnt_nxt              = '0;
            recv_nxt             = 1'b1;
            res.send_delay_start = 1'b1;
          end else begin
            res.send_permit = 1'b1;
          end
        end
        dmxrdm_pkg::MODE_RDM_OUT,
        dmxrdm_pkg::MODE_RDM_IN,
        dmxrdm_pkg::MODE_DMX_RDM_IN: begin
          kind_nxt = dmxrdm_pkg::KIND_NONE;
          brk_nxt  = 1'b0;
          cnt_nxt  = '0;
          recv_nxt = 1'b1;
        end
        default: ;
      endcase
    end

    res.packet_kind   = kind_nxt;
    res.receive_armed = recv_nxt;
  end

  // State registers, updated once per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      brk_r  <= 1'b0;
      kind_r <= dmxrdm_pkg::KIND_NONE;
      recv_r <= 1'b0;
      head_r <= '0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      brk_r  <= brk_nxt;
      kind_r <= kind_nxt;
      recv_r <= recv_nxt;
      head_r <= head_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.packet_done |=> cnt_r == '0 && !recv_r)
    else $error("packet_done did not close reception");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dmxrdm_pkg::COUNT_LIMIT)
    else $error("byte count above limit");

  a_break_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.action == dmxrdm_pkg::ACT_BREAK |=>
      brk_r && recv_r && cnt_r == '0 && kind_r == dmxrdm_pkg::KIND_NONE)
    else $error("break did not restart framing");

  a_store_armed: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.store_write |-> recv_r && item.action == dmxrdm_pkg::ACT_BYTE)
    else $error("store without armed byte");
`endif

endmodule

@@ hdl/dmx_rdm_receive_framer_top.sv @@
// Channel | Handshake          | Payload
// input   | in_valid/in_stall  | in_item  (dmxrdm_pkg::in_t)
// result  | out_valid/out_stall| out_item (dmxrdm_pkg::out_t)
// config  | cfg_we             | cfg_idx, cfg_wdata
//
// One transaction per cycle sustained while out_stall stays low; a result passes from
// the input register through the framing logic into the result register, from which
// it leaves when out_stall is low.
// rst_n is synchronous: it clears framing state and loads register defaults.
// A stalled result holds; the input register keeps taking transactions until
// both it and the result register are full.
module dmx_rdm_receive_framer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  dmxrdm_pkg::in_t                    in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dmxrdm_pkg::out_t                   out_item,
  input  logic                               cfg_we,
  input  logic [dmxrdm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [dmxrdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  dmxrdm_pkg::cfg_t  cfg;
  dmxrdm_pkg::in_t   in_item_r;
  dmxrdm_pkg::out_t  out_item_r;
  dmxrdm_pkg::out_t  res;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              advance;

  dmxrdm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dmxrdm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (advance),
    .item  (in_item_r),
    .res   (res)
  );

  // Move the held transaction into the result register when it has room
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
